### src/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg: shared types and constants for the date string validator
// Holds the pattern layout, the month-length table and the struct passed
// from the parser to the calendar check.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int unsigned PatternLen = 13;
    localparam int unsigned PosW       = 4;
    localparam int unsigned YearW      = 14;
    localparam int unsigned AccW       = 7;
    localparam int unsigned MonthW     = 4;
    localparam int unsigned DayW       = 5;

    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    localparam logic [DayW-1:0] LeapFebDays = DayW'(29);

    typedef enum logic [2:0] {
        POS_YEAR_HI,
        POS_YEAR_LO,
        POS_MONTH,
        POS_DAY,
        POS_DOT,
        POS_SPACE,
        POS_DONE
    } t_pos_kind;

    // Everything the calendar check needs about one finished line
    typedef struct packed {
        logic              full;
        logic              fmt_err;
        logic [YearW-1:0]  year;
        logic [AccW-1:0]   month;
        logic [AccW-1:0]   day;
        logic              leap;
    } t_date_fields;

    function automatic t_pos_kind pos_kind(input logic [PosW-1:0] pos);
        t_pos_kind k;
        case (pos)
            PosW'(0), PosW'(1):   k = POS_YEAR_HI;
            PosW'(2), PosW'(3):   k = POS_YEAR_LO;
            PosW'(4), PosW'(8),
            PosW'(12):            k = POS_DOT;
            PosW'(5), PosW'(9):   k = POS_SPACE;
            PosW'(6), PosW'(7):   k = POS_MONTH;
            PosW'(10), PosW'(11): k = POS_DAY;
            default:              k = POS_DONE;
        endcase
        return k;
    endfunction

    // Non-leap month lengths, month numbered 1..12
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m);
        logic [DayW-1:0] d;
        case (m)
            MonthW'(2):                                     d = DayW'(28);
            MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11): d = DayW'(30);
            default:                                        d = DayW'(31);
        endcase
        return d;
    endfunction

endpackage

### src/dsv_calendar.sv
// ----------------------------------------------------------------------------
// dsv_calendar: calendar check of a parsed date
// Decides whether the parsed year, month and day form a real Gregorian date.
// ----------------------------------------------------------------------------
module dsv_calendar (
    input  dsv_pkg::t_date_fields i_fields,
    output logic                  o_ok
);

    logic                      month_ok;
    logic [dsv_pkg::DayW-1:0]  dim;
    logic [dsv_pkg::MonthW-1:0] month_n;

    assign month_ok = (i_fields.month >= dsv_pkg::AccW'(1))
                   && (i_fields.month <= dsv_pkg::AccW'(12));
    assign month_n  = i_fields.month[dsv_pkg::MonthW-1:0];

    always_comb begin
        if (i_fields.leap && month_n == dsv_pkg::MonthW'(2)) begin
            dim = dsv_pkg::LeapFebDays;
        end else begin
            dim = dsv_pkg::month_days(month_n);
        end
    end

    assign o_ok = i_fields.full && !i_fields.fmt_err && month_ok
               && (i_fields.year != '0)
               && (i_fields.day >= dsv_pkg::AccW'(1))
               && (i_fields.day <= dsv_pkg::AccW'(dim));

endmodule

### src/date_string_validator.sv
// ----------------------------------------------------------------------------
// date_string_validator: checks a "YYYY. MM. DD." date line
// Parses one byte per transfer and reports the date at the end of the line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one ASCII byte per
//   transfer in i_ch, with i_line_end high on the last byte of a line.
//   Output channel (o_out_valid / i_out_stall) carries one result per line:
//   o_valid_res and the parsed year, month and day (all zero if invalid).
//   The byte ending a line produces its result in the output register in
//   the cycle after the transfer. Throughput is one byte per cycle while
//   o_in_stall is low; lines then run back to back with no gap.
//   Year, month and day accumulate as digits arrive, and the leap-year test
//   is tracked from the year digits as they pass, so the end-of-line check
//   is one short compare against the month-length table.
//   Bytes beyond the thirteenth are ignored until the line end.
//   Reset (synchronous, active low) clears the parser and empties the
//   output register. While a result sits in the output register and the
//   receiver stalls, o_in_stall is raised and the input holds.
// ----------------------------------------------------------------------------
module date_string_validator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_ch,
    input  logic                       i_line_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_valid_res,
    output logic [dsv_pkg::YearW-1:0]  o_year,
    output logic [dsv_pkg::MonthW-1:0] o_month,
    output logic [dsv_pkg::DayW-1:0]   o_day
);

    logic [dsv_pkg::PosW-1:0]   r_pos,   n_pos;
    logic                       r_err,   n_err;
    logic [dsv_pkg::YearW-1:0]  r_year,  n_year;
    logic [dsv_pkg::AccW-1:0]   r_month, n_month;
    logic [dsv_pkg::AccW-1:0]   r_day,   n_day;
    logic [1:0]                 r_hi_m4, n_hi_m4;
    logic [1:0]                 r_lo_m4, n_lo_m4;
    logic                       r_lo_zero, n_lo_zero;

    logic                       r_out_vld;
    logic                       r_res_ok;
    logic [dsv_pkg::YearW-1:0]  r_res_year;
    logic [dsv_pkg::MonthW-1:0] r_res_month;
    logic [dsv_pkg::DayW-1:0]   r_res_day;

    logic                       in_xfer;
    logic                       out_free;
    logic                       is_digit;
    logic [3:0]                 digit;
    dsv_pkg::t_pos_kind         kind;
    dsv_pkg::t_date_fields      fields;
    logic                       date_ok;

    assign o_in_stall = r_out_vld && i_out_stall;
    assign out_free   = !o_in_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign is_digit = (i_ch >= dsv_pkg::ChZero) && (i_ch <= dsv_pkg::ChNine);
    assign digit    = i_ch[3:0];
    assign kind     = dsv_pkg::pos_kind(r_pos);

    always_comb begin
        n_pos     = r_pos;
        n_err     = r_err;
        n_year    = r_year;
        n_month   = r_month;
        n_day     = r_day;
        n_hi_m4   = r_hi_m4;
        n_lo_m4   = r_lo_m4;
        n_lo_zero = r_lo_zero;
        if (kind != dsv_pkg::POS_DONE) begin
            n_pos = r_pos + dsv_pkg::PosW'(1);
        end
        case (kind)
            dsv_pkg::POS_DOT: begin
                if (i_ch != dsv_pkg::ChDot) n_err = 1'b1;
            end
            dsv_pkg::POS_SPACE: begin
                if (i_ch != dsv_pkg::ChSpace) n_err = 1'b1;
            end
            dsv_pkg::POS_YEAR_HI, dsv_pkg::POS_YEAR_LO: begin
                if (!is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_year = {r_year[dsv_pkg::YearW-4:0], 3'b000}
                           + {r_year[dsv_pkg::YearW-2:0], 1'b0}
                           + dsv_pkg::YearW'(digit);
                    // (10a + b) mod 4 == (2a + b) mod 4
                    if (kind == dsv_pkg::POS_YEAR_HI) begin
                        n_hi_m4 = {r_hi_m4[0], 1'b0} + digit[1:0];
                    end else begin
                        n_lo_m4   = {r_lo_m4[0], 1'b0} + digit[1:0];
                        n_lo_zero = r_lo_zero && (digit == 4'd0);
                    end
                end
            end
            dsv_pkg::POS_MONTH: begin
                if (!is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_month = {r_month[dsv_pkg::AccW-4:0], 3'b000}
                            + {r_month[dsv_pkg::AccW-2:0], 1'b0}
                            + dsv_pkg::AccW'(digit);
                end
            end
            dsv_pkg::POS_DAY: begin
                if (!is_digit) begin
                    n_err = 1'b1;
                end else begin
                    n_day = {r_day[dsv_pkg::AccW-4:0], 3'b000}
                          + {r_day[dsv_pkg::AccW-2:0], 1'b0}
                          + dsv_pkg::AccW'(digit);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        fields.full    = (n_pos == dsv_pkg::PosW'(dsv_pkg::PatternLen));
        fields.fmt_err = n_err;
        fields.year    = n_year;
        fields.month   = n_month;
        fields.day     = n_day;
        fields.leap    = (n_lo_zero && n_hi_m4 == 2'd0)
                      || (!n_lo_zero && n_lo_m4 == 2'd0);
    end

    dsv_calendar u_calendar (
        .i_fields (fields),
        .o_ok     (date_ok)
    );

    // Parser state: advance on each transfer, clear after the line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_xfer && i_line_end)) begin
            r_pos     <= '0;
            r_err     <= 1'b0;
            r_year    <= '0;
            r_month   <= '0;
            r_day     <= '0;
            r_hi_m4   <= '0;
            r_lo_m4   <= '0;
            r_lo_zero <= 1'b1;
        end else if (in_xfer) begin
            r_pos     <= n_pos;
            r_err     <= n_err;
            r_year    <= n_year;
            r_month   <= n_month;
            r_day     <= n_day;
            r_hi_m4   <= n_hi_m4;
            r_lo_m4   <= n_lo_m4;
            r_lo_zero <= n_lo_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= in_xfer && i_line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && in_xfer && i_line_end) begin
            r_res_ok    <= date_ok;
            r_res_year  <= date_ok ? n_year : '0;
            r_res_month <= date_ok ? n_month[dsv_pkg::MonthW-1:0] : '0;
            r_res_day   <= date_ok ? n_day[dsv_pkg::DayW-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_valid_res = r_res_ok;
    assign o_year      = r_res_year;
    assign o_month     = r_res_month;
    assign o_day       = r_res_day;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= dsv_pkg::PosW'(dsv_pkg::PatternLen))
        else $error("pattern position ran past the pattern length");

    a_line_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_line_end |=> o_out_valid)
        else $error("line end transfer gave no result");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |->
            o_month >= dsv_pkg::MonthW'(1) && o_month <= dsv_pkg::MonthW'(12)
            && o_day != '0 && o_year != '0)
        else $error("valid date carries an out-of-range field");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |-> o_year == '0 && o_month == '0 && o_day == '0)
        else $error("invalid date carries nonzero fields");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_line_end |=> r_pos == '0 && !r_err)
        else $error("parser not cleared after line end");

endmodule
